>>> rtl/mexp_pkg.sv
// shared types and constants for the modular exponentiation block
// no dependencies
package mexp_pkg;

  // width of the message, result and configuration data fields
  localparam int unsigned FIELD_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS = 1;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // configuration register indices
  localparam cfg_idx_t REG_MODULUS  = 1'b0;
  localparam cfg_idx_t REG_EXPONENT = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MUL_R  = 5'b01000,
    S_MUL_B  = 5'b10000
  } state_e;

  // output slot wait is handled by the top level, which holds the sequencer in the scan state
  typedef enum logic [1:0] {
    OUT_EMPTY = 2'b01,
    OUT_FULL  = 2'b10
  } out_slot_e;

endpackage

>>> rtl/mexp_mulmod.sv
// bit-serial modular multiplier: a * b mod n, one multiplier bit per cycle
// does not depend on mexp_pkg (no imports needed)
module mexp_mulmod #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] n_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;

  logic [W+1:0] n_ext, n2_ext, t, t_n, t_2n;
  logic [W-1:0] step;

  // acc stays below n, a is at most n, so 2*acc + a stays below 3n
  assign n_ext  = (W+2)'(n_i);
  assign n2_ext = n_ext << 1;
  assign t      = ({2'b00, acc_q} << 1) + (b_q[W-1] ? (W+2)'(a_q) : '0);
  assign t_n    = t - n_ext;
  assign t_2n   = t - n2_ext;

  always_comb begin
    if (n_i == '0) begin
      step = t[W-1:0];                  // no modulus: wrap at word width
    end else if (t >= n2_ext) begin
      step = t_2n[W-1:0];
    end else if (t >= n_ext) begin
      step = t_n[W-1:0];
    end else begin
      step = t[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W - 1);
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (busy_q) begin
      acc_d = step;
      b_d   = b_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

`ifndef NO_ASSERTIONS
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("done without a running multiplication");
  a_prod_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (n_i != '0)) |-> (acc_q < n_i))
    else $error("product not reduced below modulus");
`endif

endmodule

>>> rtl/modular_exponentiation.sv
// top level of the modular exponentiation block: configuration, sequencer, output slot
// depends on mexp_pkg and mexp_mulmod
//
// Computes power_result = message ^ key_exponent mod modulus, one result per request.
// Software writes modulus (index 0) and key_exponent (index 1) while the block is idle;
// after reset they hold 1 and 0. A request first reduces the message modulo the modulus,
// then scans the exponent from its least significant bit: a set bit multiplies the
// running result by the base, and the base is squared while higher set bits remain.
// Every multiplication runs on one shared bit-serial unit that handles one multiplier bit
// a cycle. An exponent of zero gives 1 once the base reduction is done, even for
// modulus 1, and a modulus of zero skips the reduction and makes the arithmetic wrap at
// the word width. The block takes no new request while one is in work; a finished
// result sits in an output register, so the next request can start while that result
// waits to be taken.
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  mexp_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [mexp_pkg::FIELD_BITS-1:0]     cfg_data_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mexp_pkg::FIELD_BITS-1:0]     message_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mexp_pkg::FIELD_BITS-1:0]     power_result_o
);

  import mexp_pkg::*;

  localparam int unsigned W = WORD_BITS;

  // configuration registers, taken modulo 2^W
  logic [W-1:0] modulus_q, exponent_q;
  logic [63:0]  cfg_wide;

  // working registers of one request
  state_e       state_q, state_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] result_q, result_d;
  logic [W-1:0] exp_q, exp_d;

  // output slot
  out_slot_e                slot_q, slot_d;
  logic [FIELD_BITS-1:0]    out_data_q, out_data_d;

  // shared multiplier
  logic         mm_start;
  logic [W-1:0] mm_a, mm_b;
  logic         mm_busy, mm_done;
  logic [W-1:0] mm_prod;

  logic [63:0]  msg_wide, res_wide;
  logic         in_take, out_take, finish;

  assign cfg_wide = 64'(cfg_data_i);
  assign msg_wide = 64'(message_i);

  // configuration decoder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= W'(1);
      exponent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODULUS:  modulus_q  <= cfg_wide[W-1:0];
        REG_EXPONENT: exponent_q <= cfg_wide[W-1:0];
        default: ;
      endcase
    end
  end

  // a request is taken only when the sequencer is idle
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;

  // sequencer
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    result_d = result_q;
    exp_d    = exp_q;
    mm_start = 1'b0;
    mm_a     = base_q;
    mm_b     = base_q;
    finish   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          base_d   = msg_wide[W-1:0];
          result_d = W'(1);
          exp_d    = exponent_q;
          if (modulus_q != '0) begin
            // reduce the message: message * 1 mod n
            mm_start = 1'b1;
            mm_a     = W'(1);
            mm_b     = msg_wide[W-1:0];
            state_d  = S_REDUCE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          base_d  = mm_prod;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (exp_q == '0) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else if (exp_q[0]) begin
          // multiply running result by base
          mm_start = 1'b1;
          mm_a     = base_q;
          mm_b     = result_q;
          state_d  = S_MUL_R;
        end else begin
          // clear bit with higher bits set: square base
          exp_d    = exp_q >> 1;
          mm_start = 1'b1;
          state_d  = S_MUL_B;
        end
      end
      S_MUL_R: begin
        if (mm_done) begin
          result_d = mm_prod;
          exp_d    = exp_q >> 1;
          if (exp_q[W-1:1] != '0) begin
            mm_start = 1'b1;
            state_d  = S_MUL_B;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_MUL_B: begin
        if (mm_done) begin
          base_d  = mm_prod;
          state_d = S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // hold the finished request until the output slot can take it
    if (finish && (slot_q == OUT_FULL) && !out_take) begin
      finish  = 1'b0;
      state_d = S_SCAN;
    end
  end

  assign res_wide = 64'(result_q);

  // output slot
  always_comb begin
    slot_d     = slot_q;
    out_data_d = out_data_q;
    if (out_take) begin
      slot_d = OUT_EMPTY;
    end
    if (finish) begin
      slot_d     = OUT_FULL;
      out_data_d = res_wide[FIELD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= OUT_EMPTY;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    result_q   <= result_d;
    exp_q      <= exp_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o    = (slot_q == OUT_FULL);
  assign power_result_o = out_data_q;

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .n_i     (modulus_q),
    .busy_o  (mm_busy),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

`ifndef NO_ASSERTIONS
  a_done_in_mul_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> ((state_q == S_REDUCE) || (state_q == S_MUL_R) || (state_q == S_MUL_B)))
    else $error("multiplier finished outside a multiply state");
  a_finish_exp_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (exp_q == '0))
    else $error("request finished with exponent bits left");
  a_busy_in_mul_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_busy |-> ((state_q == S_REDUCE) || (state_q == S_MUL_R) || (state_q == S_MUL_B)))
    else $error("multiplier running while sequencer does not wait for it");
`endif

endmodule
